### rtl/x86_486_extension_execute_unit_top_assert.svh
// ----------------------------------------------------------------------------
// x86_486_extension_execute_unit_top_assert.svh
// Assertion macros used by the checker file of the 486 extension unit.
// ----------------------------------------------------------------------------
`ifndef X86_486_EXTENSION_EXECUTE_UNIT_TOP_ASSERT_SVH
`define X86_486_EXTENSION_EXECUTE_UNIT_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define X486EXT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define X486EXT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/x486ext_pkg.sv
// ----------------------------------------------------------------------------
// x486ext_pkg
// Types, opcodes and constants of the 486 extension execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package x486ext_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned DESC_W   = 48;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // opcodes
    localparam logic [3:0] OP_CMPXCHG = 4'd0;
    localparam logic [3:0] OP_XADD    = 4'd1;
    localparam logic [3:0] OP_BSWAP   = 4'd2;
    localparam logic [3:0] OP_SMSW    = 4'd3;
    localparam logic [3:0] OP_LMSW    = 4'd4;
    localparam logic [3:0] OP_SGDT    = 4'd5;
    localparam logic [3:0] OP_SIDT    = 4'd6;
    localparam logic [3:0] OP_LGDT    = 4'd7;
    localparam logic [3:0] OP_LIDT    = 4'd8;
    localparam logic [3:0] OP_CPUID   = 4'd9;
    localparam logic [3:0] OP_WR_CR0  = 4'd10;

    // operand sizes
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;

    // fault codes
    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_UD   = 2'd1;
    localparam logic [1:0] FLT_GP   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VENDOR2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEAF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE  = 3'd5;

    localparam logic [DATA_W-1:0] MAX_LEAF_RST = 32'h0000_0001;
    localparam logic [DATA_W-1:0] MSW_MASK     = 32'h0000_000f;
    localparam logic [DATA_W-1:0] BASE16_MASK  = 32'h00ff_ffff;
    localparam logic [DATA_W-1:0] LOW16_MASK   = 32'h0000_ffff;
    localparam logic [DATA_W-1:0] PE_BIT       = 32'h0000_0001;

    // CPUID leaves
    localparam logic [DATA_W-1:0] LEAF_VENDOR  = 32'd0;
    localparam logic [DATA_W-1:0] LEAF_VERSION = 32'd1;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [1:0]         size;
        logic [DATA_W-1:0]  acc_value;
        logic [DATA_W-1:0]  rm_value;
        logic [DATA_W-1:0]  reg_value;
        logic [DESC_W-1:0]  desc_value;
        logic               prot_mode;
        logic [1:0]         cpl;
    } item_t;

    typedef struct packed {
        logic               rm_write;
        logic [DATA_W-1:0]  rm_result;
        logic               reg_write;
        logic [DATA_W-1:0]  reg_result;
        logic               acc_write;
        logic [DATA_W-1:0]  acc_result;
        logic               aux_write;
        logic [DATA_W-1:0]  aux_result;
        logic               zf_write;
        logic               zero_flag;
        logic [1:0]         fault;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] vendor0;
        logic [DATA_W-1:0] vendor1;
        logic [DATA_W-1:0] vendor2;
        logic [DATA_W-1:0] max_leaf;
        logic [DATA_W-1:0] version;
        logic [DATA_W-1:0] feature;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]  control_word;
        logic [DATA_W-1:0]  gdt_base;
        logic [LIMIT_W-1:0] gdt_limit;
        logic [DATA_W-1:0]  idt_base;
        logic [LIMIT_W-1:0] idt_limit;
    } arch_t;

    typedef struct packed {
        logic               cw_we;
        logic [DATA_W-1:0]  cw;
        logic               gdt_we;
        logic               idt_we;
        logic [LIMIT_W-1:0] limit;
        logic [DATA_W-1:0]  base;
    } upd_t;

endpackage

### rtl/x486ext_if.sv
// ----------------------------------------------------------------------------
// x486ext_cmd_if / x486ext_res_if
// Valid/ready channels for instruction words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface x486ext_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [3:0]                    opcode;
    logic [1:0]                    size;
    logic [x486ext_pkg::DATA_W-1:0] acc_value;
    logic [x486ext_pkg::DATA_W-1:0] rm_value;
    logic [x486ext_pkg::DATA_W-1:0] reg_value;
    logic [x486ext_pkg::DESC_W-1:0] desc_value;
    logic                          prot_mode;
    logic [1:0]                    cpl;

    modport source (output valid, opcode, size, acc_value, rm_value, reg_value,
                    desc_value, prot_mode, cpl, input ready);
    modport sink   (input valid, opcode, size, acc_value, rm_value, reg_value,
                    desc_value, prot_mode, cpl, output ready);
endinterface

interface x486ext_res_if;
    logic                          valid;
    logic                          ready;
    logic                          rm_write;
    logic [x486ext_pkg::DATA_W-1:0] rm_result;
    logic                          reg_write;
    logic [x486ext_pkg::DATA_W-1:0] reg_result;
    logic                          acc_write;
    logic [x486ext_pkg::DATA_W-1:0] acc_result;
    logic                          aux_write;
    logic [x486ext_pkg::DATA_W-1:0] aux_result;
    logic                          zf_write;
    logic                          zero_flag;
    logic [1:0]                    fault;

    modport source (output valid, rm_write, rm_result, reg_write, reg_result,
                    acc_write, acc_result, aux_write, aux_result, zf_write,
                    zero_flag, fault, input ready);
    modport sink   (input valid, rm_write, rm_result, reg_write, reg_result,
                    acc_write, acc_result, aux_write, aux_result, zf_write,
                    zero_flag, fault, output ready);
endinterface

### rtl/x486ext_cfg_regs.sv
// ----------------------------------------------------------------------------
// x486ext_cfg_regs
// CPUID vendor, version and feature registers behind the write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x486ext_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [x486ext_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [x486ext_pkg::DATA_W-1:0]    cfg_data,
    output x486ext_pkg::cfg_t                 cfg
);

    x486ext_pkg::cfg_t cfg_reg;
    x486ext_pkg::cfg_t cfg_next;

    // decode the write; indexes past the last register are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                x486ext_pkg::CFG_VENDOR0:  cfg_next.vendor0  = cfg_data;
                x486ext_pkg::CFG_VENDOR1:  cfg_next.vendor1  = cfg_data;
                x486ext_pkg::CFG_VENDOR2:  cfg_next.vendor2  = cfg_data;
                x486ext_pkg::CFG_MAX_LEAF: cfg_next.max_leaf = cfg_data;
                x486ext_pkg::CFG_VERSION:  cfg_next.version  = cfg_data;
                x486ext_pkg::CFG_FEATURE:  cfg_next.feature  = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{vendor0:  '0,
                         vendor1:  '0,
                         vendor2:  '0,
                         max_leaf: x486ext_pkg::MAX_LEAF_RST,
                         version:  '0,
                         feature:  '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/x486ext_arch_state.sv
// ----------------------------------------------------------------------------
// x486ext_arch_state
// Control word and GDT/IDT base and limit registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x486ext_arch_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                commit,
    input  x486ext_pkg::upd_t   upd,
    output x486ext_pkg::arch_t  arch
);

    x486ext_pkg::arch_t arch_reg;
    x486ext_pkg::arch_t arch_next;

    // apply the update of the word leaving the execute stage
    always_comb
    begin
        arch_next = arch_reg;
        if (commit)
        begin
            if (upd.cw_we)
                arch_next.control_word = upd.cw;
            if (upd.gdt_we)
            begin
                arch_next.gdt_base  = upd.base;
                arch_next.gdt_limit = upd.limit;
            end
            if (upd.idt_we)
            begin
                arch_next.idt_base  = upd.base;
                arch_next.idt_limit = upd.limit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arch_reg <= '0;
        else
            arch_reg <= arch_next;
    end

    assign arch = arch_reg;

endmodule

### rtl/x486ext_exec.sv
// ----------------------------------------------------------------------------
// x486ext_exec
// Combinational execute logic: one instruction word to one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x486ext_exec (
    input  x486ext_pkg::item_t   item,
    input  x486ext_pkg::arch_t   arch,
    input  x486ext_pkg::cfg_t    cfg,
    output x486ext_pkg::result_t res,
    output x486ext_pkg::upd_t    upd
);

    logic [x486ext_pkg::DATA_W-1:0] op_mask;
    logic [x486ext_pkg::DATA_W-1:0] base_mask;
    logic [x486ext_pkg::DATA_W-1:0] sum;
    logic [x486ext_pkg::DATA_W-1:0] rm;
    logic [x486ext_pkg::DATA_W-1:0] msw;
    logic                           priv_fault;

    // operand width masks; size three acts as 32 bits
    always_comb
    begin
        case (item.size)
            x486ext_pkg::SZ_8:  op_mask = 32'h0000_00ff;
            x486ext_pkg::SZ_16: op_mask = x486ext_pkg::LOW16_MASK;
            default:            op_mask = 32'hffff_ffff;
        endcase
    end

    assign base_mask  = (item.size == x486ext_pkg::SZ_16) ? x486ext_pkg::BASE16_MASK
                                                          : 32'hffff_ffff;
    assign rm         = item.rm_value;
    assign sum        = rm + item.reg_value;
    assign priv_fault = item.prot_mode && (item.cpl != 2'd0);
    // LMSW can set PE but never clear it in protected mode
    assign msw        = (rm | (item.prot_mode ? x486ext_pkg::PE_BIT : '0))
                        & x486ext_pkg::MSW_MASK;

    // opcode decode
    always_comb
    begin
        res       = '0;
        upd       = '0;
        upd.limit = item.desc_value[x486ext_pkg::LIMIT_W-1:0];
        upd.base  = item.desc_value[x486ext_pkg::DESC_W-1:x486ext_pkg::LIMIT_W] & base_mask;
        upd.cw    = rm;
        unique case (item.opcode)
            x486ext_pkg::OP_CMPXCHG:
            begin
                res.zf_write = 1'b1;
                if ((item.acc_value & op_mask) == (rm & op_mask))
                begin
                    res.rm_write  = 1'b1;
                    res.rm_result = item.reg_value & op_mask;
                    res.zero_flag = 1'b1;
                end
                else
                begin
                    res.acc_write  = 1'b1;
                    res.acc_result = rm & op_mask;
                end
            end
            x486ext_pkg::OP_XADD:
            begin
                res.rm_write   = 1'b1;
                res.rm_result  = sum & op_mask;
                res.reg_write  = 1'b1;
                res.reg_result = rm & op_mask;
            end
            x486ext_pkg::OP_BSWAP:
            begin
                res.rm_write  = 1'b1;
                res.rm_result = {rm[7:0], rm[15:8], rm[23:16], rm[31:24]};
            end
            x486ext_pkg::OP_SMSW:
            begin
                res.rm_write  = 1'b1;
                res.rm_result = arch.control_word & x486ext_pkg::LOW16_MASK;
            end
            x486ext_pkg::OP_LMSW:
            begin
                if (priv_fault)
                    res.fault = x486ext_pkg::FLT_GP;
                else
                begin
                    upd.cw_we = 1'b1;
                    upd.cw    = (arch.control_word & ~x486ext_pkg::MSW_MASK) | msw;
                end
            end
            x486ext_pkg::OP_SGDT:
            begin
                res.rm_write   = 1'b1;
                res.rm_result  = {16'd0, arch.gdt_limit};
                res.aux_write  = 1'b1;
                res.aux_result = arch.gdt_base & base_mask;
            end
            x486ext_pkg::OP_SIDT:
            begin
                res.rm_write   = 1'b1;
                res.rm_result  = {16'd0, arch.idt_limit};
                res.aux_write  = 1'b1;
                res.aux_result = arch.idt_base & base_mask;
            end
            x486ext_pkg::OP_LGDT:
            begin
                if (priv_fault)
                    res.fault = x486ext_pkg::FLT_GP;
                else
                    upd.gdt_we = 1'b1;
            end
            x486ext_pkg::OP_LIDT:
            begin
                if (priv_fault)
                    res.fault = x486ext_pkg::FLT_GP;
                else
                    upd.idt_we = 1'b1;
            end
            x486ext_pkg::OP_CPUID:
            begin
                if (cfg.vendor0 == '0)
                    res.fault = x486ext_pkg::FLT_UD;
                else if (item.acc_value == x486ext_pkg::LEAF_VENDOR)
                begin
                    res.acc_write  = 1'b1;
                    res.acc_result = cfg.max_leaf;
                    res.reg_write  = 1'b1;
                    res.reg_result = cfg.vendor0;
                    res.rm_write   = 1'b1;
                    res.rm_result  = cfg.vendor2;
                    res.aux_write  = 1'b1;
                    res.aux_result = cfg.vendor1;
                end
                else if (item.acc_value == x486ext_pkg::LEAF_VERSION)
                begin
                    res.acc_write  = 1'b1;
                    res.acc_result = cfg.version;
                    res.aux_write  = 1'b1;
                    res.aux_result = cfg.feature;
                end
            end
            x486ext_pkg::OP_WR_CR0:
            begin
                if (priv_fault)
                    res.fault = x486ext_pkg::FLT_GP;
                else
                    upd.cw_we = 1'b1;
            end
            default:
            begin
                res.fault = x486ext_pkg::FLT_UD;
            end
        endcase
    end

endmodule

### rtl/x86_486_extension_execute_unit_top.sv
// ----------------------------------------------------------------------------
// x86_486_extension_execute_unit_top
// Execute unit for CMPXCHG, XADD, BSWAP, MSW/descriptor table ops and CPUID.
// Each accepted instruction word passes the input register, decode logic and
// the result register; throughput 1 word per cycle while results are taken.
// A stalled result register holds the input register, which backpressures in.
// Reset: async active low; control word and tables clear, max_leaf reads 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86_486_extension_execute_unit_top (
    input  logic                              clk,
    input  logic                              rst_n,
    x486ext_cmd_if.sink                       cmd,
    x486ext_res_if.source                     res,
    input  logic                              cfg_we,
    input  logic [x486ext_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [x486ext_pkg::DATA_W-1:0]    cfg_data
);

    x486ext_pkg::item_t   item_reg;
    logic                 item_vld_reg;
    x486ext_pkg::result_t res_reg;
    logic                 res_vld_reg;

    x486ext_pkg::item_t   item_in;
    x486ext_pkg::result_t res_next;
    x486ext_pkg::upd_t    upd;
    x486ext_pkg::arch_t   arch;
    x486ext_pkg::cfg_t    cfg;
    logic                 advance;
    logic                 take_in;

    // pipeline control: execute moves forward when the result slot frees up
    assign advance = item_vld_reg && (!res_vld_reg || res.ready);
    assign take_in = cmd.valid && cmd.ready;
    assign cmd.ready = !item_vld_reg || advance;

    assign item_in = '{opcode:     cmd.opcode,
                       size:       cmd.size,
                       acc_value:  cmd.acc_value,
                       rm_value:   cmd.rm_value,
                       reg_value:  cmd.reg_value,
                       desc_value: cmd.desc_value,
                       prot_mode:  cmd.prot_mode,
                       cpl:        cmd.cpl};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_vld_reg <= 1'b0;
        else if (cmd.ready)
            item_vld_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            item_reg <= item_in;
    end

    x486ext_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    x486ext_arch_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .upd    (upd),
        .arch   (arch)
    );

    x486ext_exec u_exec (
        .item (item_reg),
        .arch (arch),
        .cfg  (cfg),
        .res  (res_next),
        .upd  (upd)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (advance)
            res_vld_reg <= 1'b1;
        else if (res.ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign res.valid      = res_vld_reg;
    assign res.rm_write   = res_reg.rm_write;
    assign res.rm_result  = res_reg.rm_result;
    assign res.reg_write  = res_reg.reg_write;
    assign res.reg_result = res_reg.reg_result;
    assign res.acc_write  = res_reg.acc_write;
    assign res.acc_result = res_reg.acc_result;
    assign res.aux_write  = res_reg.aux_write;
    assign res.aux_result = res_reg.aux_result;
    assign res.zf_write   = res_reg.zf_write;
    assign res.zero_flag  = res_reg.zero_flag;
    assign res.fault      = res_reg.fault;

endmodule

### rtl/x486ext_checker.sv
// ----------------------------------------------------------------------------
// x486ext_checker
// Port-level checks on result words of the 486 extension execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "x86_486_extension_execute_unit_top_assert.svh"

module x486ext_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           rm_write,
    input logic [x486ext_pkg::DATA_W-1:0] rm_result,
    input logic                           reg_write,
    input logic                           acc_write,
    input logic                           aux_write,
    input logic                           zf_write,
    input logic                           zero_flag,
    input logic [1:0]                     fault
);

    // a faulting word writes nothing back
    `X486EXT_ASSERT_IMP(a_fault_no_write, out_valid && (fault != x486ext_pkg::FLT_NONE), !rm_write && !reg_write && !acc_write && !aux_write && !zf_write, "write bit set on a faulting word")

    // ZF only reported together with its write strobe
    `X486EXT_ASSERT_IMP(a_zf_strobe, out_valid && zero_flag, zf_write, "zero_flag without zf_write")

    // a cmpxchg outcome writes exactly one of rm and accumulator
    `X486EXT_ASSERT_IMP(a_cmpxchg_one_dest, out_valid && zf_write, (rm_write == zero_flag) && (acc_write == !zero_flag), "cmpxchg destination does not match ZF")

    // unwritten rm result reads as zero
    `X486EXT_ASSERT_IMP(a_rm_zero, out_valid && !rm_write, rm_result == '0, "rm_result nonzero without rm_write")

    // a stalled result word holds
    `X486EXT_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(rm_result) && $stable(fault), "result word changed while stalled")

endmodule

bind x86_486_extension_execute_unit_top x486ext_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .rm_write  (res.rm_write),
    .rm_result (res.rm_result),
    .reg_write (res.reg_write),
    .acc_write (res.acc_write),
    .aux_write (res.aux_write),
    .zf_write  (res.zf_write),
    .zero_flag (res.zero_flag),
    .fault     (res.fault)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 486 extension execute unit. A short table of
// hand-picked instructions (reset values, faults, operand size extremes) runs
// first, then random instruction streams under six CPUID register settings.
// Every result word is checked against its typed-in value or an in-bench model
// of the unit, random stalls on both channels and two long result hold-offs.
// ----------------------------------------------------------------------------

module tb;

    import x486ext_pkg::*;

    localparam int RAND_PER_CFG  = 242;
    localparam int NUM_CFG       = 6;
    localparam int HOLD_CYCLES   = 64;
    localparam int END_WAIT      = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;

    // one row of the directed table; use_want selects the typed-in result
    typedef struct packed {
        item_t   w;
        logic    use_want;
        result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    x486ext_cmd_if cmd_bus ();
    x486ext_res_if res_bus ();

    x86_486_extension_execute_unit_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model state, mirrored CPUID registers and result words in flight
    arch_t   arch_q;
    cfg_t    cpuid_cfg;
    result_t pending_results [$];

    int  src_idle_pct;
    int  snk_idle_pct;
    bit  hold_req;
    int  mismatches;
    int  quiet_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // model of the unit
    // ------------------------------------------------------------------------
    function automatic logic [DATA_W-1:0] operand_mask(input logic [1:0] sz);
        if (sz == SZ_8)
            return 32'h0000_00ff;
        if (sz == SZ_16)
            return LOW16_MASK;
        return '1;
    endfunction

    function automatic result_t execute_ext_op(input item_t w);
        result_t           r;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] bmask;
        logic [DATA_W-1:0] b;
        logic              priv;
        r     = '0;
        m     = operand_mask(w.size);
        bmask = (w.size == SZ_16) ? BASE16_MASK : '1;
        priv  = w.prot_mode && (w.cpl != 2'd0);
        case (w.opcode)
            OP_CMPXCHG:
            begin
                r.zf_write = 1'b1;
                if ((w.acc_value & m) == (w.rm_value & m))
                begin
                    r.rm_write  = 1'b1;
                    r.rm_result = w.reg_value & m;
                    r.zero_flag = 1'b1;
                end
                else
                begin
                    r.acc_write  = 1'b1;
                    r.acc_result = w.rm_value & m;
                end
            end
            OP_XADD:
            begin
                r.rm_write   = 1'b1;
                r.rm_result  = (w.rm_value + w.reg_value) & m;
                r.reg_write  = 1'b1;
                r.reg_result = w.rm_value & m;
            end
            OP_BSWAP:
            begin
                r.rm_write  = 1'b1;
                r.rm_result = {w.rm_value[7:0], w.rm_value[15:8],
                               w.rm_value[23:16], w.rm_value[31:24]};
            end
            OP_SMSW:
            begin
                r.rm_write  = 1'b1;
                r.rm_result = arch_q.control_word & LOW16_MASK;
            end
            OP_LMSW:
            begin
                if (priv)
                    r.fault = FLT_GP;
                else
                begin
                    // protection enable can be set here but never cleared in PM
                    b = w.rm_value & LOW16_MASK;
                    if (w.prot_mode)
                        b = b | PE_BIT;
                    arch_q.control_word = (arch_q.control_word & ~MSW_MASK) | (b & MSW_MASK);
                end
            end
            OP_SGDT:
            begin
                r.rm_write   = 1'b1;
                r.rm_result  = {16'h0000, arch_q.gdt_limit};
                r.aux_write  = 1'b1;
                r.aux_result = arch_q.gdt_base & bmask;
            end
            OP_SIDT:
            begin
                r.rm_write   = 1'b1;
                r.rm_result  = {16'h0000, arch_q.idt_limit};
                r.aux_write  = 1'b1;
                r.aux_result = arch_q.idt_base & bmask;
            end
            OP_LGDT:
            begin
                if (priv)
                    r.fault = FLT_GP;
                else
                begin
                    arch_q.gdt_limit = w.desc_value[15:0];
                    arch_q.gdt_base  = w.desc_value[47:16] & bmask;
                end
            end
            OP_LIDT:
            begin
                if (priv)
                    r.fault = FLT_GP;
                else
                begin
                    arch_q.idt_limit = w.desc_value[15:0];
                    arch_q.idt_base  = w.desc_value[47:16] & bmask;
                end
            end
            OP_CPUID:
            begin
                if (cpuid_cfg.vendor0 == '0)
                    r.fault = FLT_UD;
                else if (w.acc_value == LEAF_VENDOR)
                begin
                    r.acc_write  = 1'b1;
                    r.acc_result = cpuid_cfg.max_leaf;
                    r.reg_write  = 1'b1;
                    r.reg_result = cpuid_cfg.vendor0;
                    r.rm_write   = 1'b1;
                    r.rm_result  = cpuid_cfg.vendor2;
                    r.aux_write  = 1'b1;
                    r.aux_result = cpuid_cfg.vendor1;
                end
                else if (w.acc_value == LEAF_VERSION)
                begin
                    r.acc_write  = 1'b1;
                    r.acc_result = cpuid_cfg.version;
                    r.aux_write  = 1'b1;
                    r.aux_result = cpuid_cfg.feature;
                end
            end
            OP_WR_CR0:
            begin
                if (priv)
                    r.fault = FLT_GP;
                else
                    arch_q.control_word = w.rm_value;
            end
            default:
                r.fault = FLT_UD;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic item_t make_item(input logic [3:0] op, input logic [1:0] sz,
                                        input logic [31:0] acc, input logic [31:0] rm,
                                        input logic [31:0] rg, input logic [47:0] desc,
                                        input logic pm, input logic [1:0] pl);
        item_t w;
        w.opcode     = op;
        w.size       = sz;
        w.acc_value  = acc;
        w.rm_value   = rm;
        w.reg_value  = rg;
        w.desc_value = desc;
        w.prot_mode  = pm;
        w.cpl        = pl;
        return w;
    endfunction

    function automatic result_t expect_word(input logic rm_we, input logic [31:0] rm,
                                            input logic aux_we, input logic [31:0] aux,
                                            input logic [1:0] flt);
        result_t r;
        r            = '0;
        r.rm_write   = rm_we;
        r.rm_result  = rm;
        r.aux_write  = aux_we;
        r.aux_result = aux;
        r.fault      = flt;
        return r;
    endfunction

    // biased toward zero, all ones and the sign bit
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t             w;
        logic [DATA_W-1:0] m;
        if ($urandom_range(99) < 92)
            w.opcode = 4'($urandom_range(10));
        else
            w.opcode = 4'($urandom_range(15, 11));
        w.size       = 2'($urandom_range(3));
        w.rm_value   = pick_word();
        w.reg_value  = pick_word();
        w.acc_value  = pick_word();
        w.desc_value = {pick_word(), 16'($urandom)};
        w.prot_mode  = 1'($urandom_range(1));
        w.cpl        = $urandom_range(1) ? 2'd0 : 2'($urandom_range(3));
        // half the compares match in the live operand bits
        if (w.opcode == OP_CMPXCHG && $urandom_range(1))
        begin
            m           = operand_mask(w.size);
            w.acc_value = (w.rm_value & m) | ($urandom & ~m);
        end
        if (w.opcode == OP_CPUID)
        begin
            case ($urandom_range(3))
                0: w.acc_value = LEAF_VENDOR;
                1: w.acc_value = LEAF_VERSION;
                2: w.acc_value = 32'($urandom_range(7, 2));
                default: w.acc_value = pick_word();
            endcase
        end
        return w;
    endfunction

    // offer one instruction word, record its expected result once taken
    task automatic send_word(input item_t w, input logic use_want, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.opcode     <= w.opcode;
        cmd_bus.size       <= w.size;
        cmd_bus.acc_value  <= w.acc_value;
        cmd_bus.rm_value   <= w.rm_value;
        cmd_bus.reg_value  <= w.reg_value;
        cmd_bus.desc_value <= w.desc_value;
        cmd_bus.prot_mode  <= w.prot_mode;
        cmd_bus.cpl        <= w.cpl;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        predicted = execute_ext_op(w);
        pending_results.push_back(use_want ? want : predicted);
    endtask

    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // write all six CPUID registers back to back, unit idle
    task automatic load_cpuid_regs(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VENDOR0;
        cfg_data  <= c.vendor0;
        @(posedge clk);
        cfg_index <= CFG_VENDOR1;
        cfg_data  <= c.vendor1;
        @(posedge clk);
        cfg_index <= CFG_VENDOR2;
        cfg_data  <= c.vendor2;
        @(posedge clk);
        cfg_index <= CFG_MAX_LEAF;
        cfg_data  <= c.max_leaf;
        @(posedge clk);
        cfg_index <= CFG_VERSION;
        cfg_data  <= c.version;
        @(posedge clk);
        cfg_index <= CFG_FEATURE;
        cfg_data  <= c.feature;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cpuid_cfg = c;
    endtask

    // ------------------------------------------------------------------------
    // result side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
                res_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // result checker and activity counter
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (res_bus.valid && res_bus.ready)
            begin
                got.rm_write   = res_bus.rm_write;
                got.rm_result  = res_bus.rm_result;
                got.reg_write  = res_bus.reg_write;
                got.reg_result = res_bus.reg_result;
                got.acc_write  = res_bus.acc_write;
                got.acc_result = res_bus.acc_result;
                got.aux_write  = res_bus.aux_write;
                got.aux_result = res_bus.aux_result;
                got.zf_write   = res_bus.zf_write;
                got.zero_flag  = res_bus.zero_flag;
                got.fault      = res_bus.fault;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result word with nothing outstanding", $realtime);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch want rm %b/%h reg %b/%h", $realtime,
                                     want.rm_write, want.rm_result, want.reg_write,
                                     want.reg_result,
                                     " acc %b/%h aux %b/%h zf %b/%b flt %0d",
                                     want.acc_write, want.acc_result, want.aux_write,
                                     want.aux_result, want.zf_write, want.zero_flag,
                                     want.fault);
                            $display("%0t:          got  rm %b/%h reg %b/%h", $realtime,
                                     got.rm_write, got.rm_result, got.reg_write,
                                     got.reg_result,
                                     " acc %b/%h aux %b/%h zf %b/%b flt %0d",
                                     got.acc_write, got.acc_result, got.aux_write,
                                     got.aux_result, got.zf_write, got.zero_flag,
                                     got.fault);
                        end
                    end
                end
            end
        end
    end

    // watchdog: too long without any word moving on either channel
    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("FAIL x86_486_extension_execute_unit_top");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t directed_tab [$];
        cfg_t      cfg_plan [NUM_CFG];
        int        n;

        rst_n               = 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_VENDOR0;
        cfg_data           <= '0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.opcode     <= OP_CMPXCHG;
        cmd_bus.size       <= SZ_8;
        cmd_bus.acc_value  <= '0;
        cmd_bus.rm_value   <= '0;
        cmd_bus.reg_value  <= '0;
        cmd_bus.desc_value <= '0;
        cmd_bus.prot_mode  <= 1'b0;
        cmd_bus.cpl        <= 2'd0;
        src_idle_pct = 18;
        snk_idle_pct = 77;
        hold_req     = 1'b0;
        mismatches   = 0;
        arch_q       = '0;
        cpuid_cfg    = '0;
        cpuid_cfg.max_leaf = MAX_LEAF_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; reset values, faults and size extremes typed in
        directed_tab.push_back('{make_item(OP_SMSW, 2'd2, 0, 0, 0, 0, 1'b0, 2'd0), 1'b1,
                                 expect_word(1'b1, 0, 1'b0, 0, FLT_NONE)});
        directed_tab.push_back('{make_item(OP_SGDT, 2'd2, 0, 0, 0, 0, 1'b0, 2'd0), 1'b1,
                                 expect_word(1'b1, 0, 1'b1, 0, FLT_NONE)});
        directed_tab.push_back('{make_item(OP_SIDT, SZ_16, 0, 0, 0, 0, 1'b1, 2'd3), 1'b1,
                                 expect_word(1'b1, 0, 1'b1, 0, FLT_NONE)});
        directed_tab.push_back('{make_item(OP_CPUID, 2'd2, 0, 0, 0, 0, 1'b0, 2'd0), 1'b1,
                                 expect_word(1'b0, 0, 1'b0, 0, FLT_UD)});
        directed_tab.push_back('{make_item(4'd11, 2'd2, '1, '1, '1, '1, 1'b0, 2'd0), 1'b1,
                                 expect_word(1'b0, 0, 1'b0, 0, FLT_UD)});
        directed_tab.push_back('{make_item(4'd15, 2'd3, '1, '1, '1, '1, 1'b1, 2'd3), 1'b1,
                                 expect_word(1'b0, 0, 1'b0, 0, FLT_UD)});
        directed_tab.push_back('{make_item(OP_LMSW, 2'd2, 0, '1, 0, 0, 1'b1, 2'd3), 1'b1,
                                 expect_word(1'b0, 0, 1'b0, 0, FLT_GP)});
        directed_tab.push_back('{make_item(OP_LGDT, 2'd2, 0, 0, 0, '1, 1'b1, 2'd1), 1'b1,
                                 expect_word(1'b0, 0, 1'b0, 0, FLT_GP)});
        directed_tab.push_back('{make_item(OP_LIDT, 2'd2, 0, 0, 0, '1, 1'b1, 2'd2), 1'b1,
                                 expect_word(1'b0, 0, 1'b0, 0, FLT_GP)});
        directed_tab.push_back('{make_item(OP_WR_CR0, 2'd2, 0, '1, 0, 0, 1'b1, 2'd3), 1'b1,
                                 expect_word(1'b0, 0, 1'b0, 0, FLT_GP)});
        // cmpxchg and xadd at every operand size
        directed_tab.push_back('{make_item(OP_CMPXCHG, SZ_8, 32'h1234_5678, 32'habcd_ef78,
                                           '1, 0, 1'b0, 2'd0), 1'b0, '0});
        directed_tab.push_back('{make_item(OP_CMPXCHG, SZ_16, 0, 32'h0000_ffff, '1, 0,
                                           1'b0, 2'd0), 1'b0, '0});
        directed_tab.push_back('{make_item(OP_CMPXCHG, 2'd2, '1, '1, 0, 0, 1'b0, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_CMPXCHG, 2'd3, 0, 32'h8000_0000, '1, 0,
                                           1'b0, 2'd0), 1'b0, '0});
        directed_tab.push_back('{make_item(OP_XADD, SZ_8, 0, '1, '1, 0, 1'b0, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_XADD, SZ_16, 0, 32'h0000_ffff, 32'd1, 0,
                                           1'b0, 2'd0), 1'b0, '0});
        directed_tab.push_back('{make_item(OP_XADD, 2'd2, 0, '1, 32'd1, 0, 1'b0, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_XADD, 2'd3, 0, 32'h8000_0000, 32'h8000_0000,
                                           0, 1'b0, 2'd0), 1'b0, '0});
        directed_tab.push_back('{make_item(OP_BSWAP, 2'd2, 0, 32'h1234_5678, 0, 0,
                                           1'b0, 2'd0), 1'b0, '0});
        // msw loads in real mode, then protection enable forced on
        directed_tab.push_back('{make_item(OP_LMSW, 2'd2, 0, '1, 0, 0, 1'b0, 2'd3),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_LMSW, SZ_16, 0, 0, 0, 0, 1'b1, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_SMSW, SZ_8, 0, 0, 0, 0, 1'b0, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_WR_CR0, 2'd2, 0, '1, 0, 0, 1'b0, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_SMSW, 2'd2, 0, 0, 0, 0, 1'b0, 2'd0),
                                 1'b0, '0});
        // table bases through the 24-bit mask on both load and store
        directed_tab.push_back('{make_item(OP_LGDT, SZ_16, 0, 0, 0, '1, 1'b0, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_SGDT, 2'd2, 0, 0, 0, 0, 1'b0, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_LIDT, 2'd2, 0, 0, 0, '1, 1'b1, 2'd0),
                                 1'b0, '0});
        directed_tab.push_back('{make_item(OP_SIDT, SZ_16, 0, 0, 0, 0, 1'b0, 2'd0),
                                 1'b0, '0});

        foreach (directed_tab[i])
            send_word(directed_tab[i].w, directed_tab[i].use_want, directed_tab[i].want);

        // CPUID register settings, extremes first
        cfg_plan[0] = '{32'h756e_6547, 32'h4965_6e69, 32'h6c65_746e, 32'd1,
                        32'h0000_0400, 32'h0000_0001};
        cfg_plan[1] = '{'1, '1, '1, '1, '1, '1};
        cfg_plan[2] = '{32'd1, '0, '0, '0, '0, '0};
        cfg_plan[3] = '{$urandom | 32'd1, $urandom, $urandom, $urandom, $urandom, $urandom};
        cfg_plan[4] = '{'0, $urandom, $urandom, $urandom, $urandom, $urandom};
        cfg_plan[5] = '{32'h8000_0000, $urandom, $urandom, $urandom, $urandom, $urandom};

        for (int p = 0; p < NUM_CFG; p++)
        begin
            drain_results();
            load_cpuid_regs(cfg_plan[p]);
            for (int k = 0; k < RAND_PER_CFG; k++)
            begin
                n = p * RAND_PER_CFG + k;
                if (n < NUM_CFG * RAND_PER_CFG / 3)
                begin
                    src_idle_pct = 18;
                    snk_idle_pct = 77;
                end
                else if (n < 2 * NUM_CFG * RAND_PER_CFG / 3)
                begin
                    src_idle_pct = 77;
                    snk_idle_pct = 18;
                end
                else
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                // stall results while instructions keep coming
                if (n == 60 || n == 1100)
                    hold_req = 1'b1;
                send_word(rand_item(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (END_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS x86_486_extension_execute_unit_top");
        else
            $display("FAIL x86_486_extension_execute_unit_top");
        $finish;
    end

endmodule
